@@ rtl/bba_pkg.sv @@
// bba_pkg: shared constants, codes and types of the bitmap block allocator
// no dependencies; imported by bba_if, bba_summary and the core (bba_ram does not use it)
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

	localparam int unsigned CHUNKS_DEF       = 64;
	localparam int unsigned CHUNK_IDX_W_MAX  = 10;
	localparam int unsigned BLOCKS_PER_CHUNK = 32;
	localparam int unsigned BIT_W            = $clog2(BLOCKS_PER_CHUNK);
	localparam int unsigned INDEX_W          = 11;
	localparam int unsigned FREE_CHUNK_W     = INDEX_W - BIT_W;
	localparam int unsigned OFFSET_W         = 23;
	localparam int unsigned BYTES_W          = 13;
	localparam int unsigned STATUS_W         = 2;
	localparam int unsigned PROD_W           = INDEX_W + BYTES_W;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_POOL_FULL = 2'd1,
		ST_BAD_FREE  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FIND,
		S_MOD,
		S_OUT
	} state_t;

	// update of the chunk summary from the sequencer
	typedef struct packed {
		logic                       wr;
		logic                       open;
		logic                       full;
		logic [CHUNK_IDX_W_MAX-1:0] chunk;
	} sum_upd_t;

endpackage

`default_nettype wire

@@ rtl/bba_if.sv @@
// bba_if: request, result and register-write channel interfaces
// depends on bba_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface bba_req_if import bba_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               command;
	logic [INDEX_W-1:0] block_index;
	logic               clear_block;

	modport source (output valid, command, block_index, clear_block, input ready);
	modport sink   (input valid, command, block_index, clear_block, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [INDEX_W-1:0]  granted_index;
	logic [OFFSET_W-1:0] byte_offset;
	logic                clear_needed;
	logic [STATUS_W-1:0] status;

	modport source (output valid, granted_index, byte_offset, clear_needed, status,
		input ready);
	modport sink   (input valid, granted_index, byte_offset, clear_needed, status,
		output ready);
endinterface

interface bba_cfg_if import bba_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [BYTES_W-1:0] block_bytes;

	modport source (output valid, block_bytes, input ready);
	modport sink   (input valid, block_bytes, output ready);
endinterface

`default_nettype wire

@@ rtl/bba_ram.sv @@
// bba_ram: generic single-clock ram, one write and one read port
// registered read data, no reset on the array; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
	parameter int unsigned WIDTH  = 32,
	parameter int unsigned DEPTH  = 64,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/bba_summary.sv @@
// bba_summary: open-chunk count, per-chunk full flags and first-fit chunk search
// depends on bba_pkg (sum_upd_t)
`timescale 1ns / 1ps
`default_nettype none

module bba_summary import bba_pkg::*; #(
	parameter int unsigned CHUNKS  = CHUNKS_DEF,
	parameter int unsigned CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1,
	parameter int unsigned OPEN_W  = $clog2(CHUNKS + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sum_upd_t           upd,
	output logic      [OPEN_W-1:0]  open_cnt,
	output logic                    found,
	output logic      [CHUNK_W-1:0] found_chunk
);

	logic [CHUNKS-1:0] full_q;
	logic [OPEN_W-1:0] open_q;
	logic [CHUNKS-1:0] avail;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
			open_q <= '0;
		end else begin
			if (upd.wr) begin
				full_q[CHUNK_W'(upd.chunk)] <= upd.full;
			end
			if (upd.open) begin
				open_q <= open_q + OPEN_W'(1);
			end
		end
	end

	// lowest open chunk with room
	always_comb begin
		found       = 1'b0;
		found_chunk = '0;
		for (int n = 0; n < CHUNKS; n++) begin
			avail[n] = (OPEN_W'(n) < open_q) && !full_q[n];
		end
		for (int n = CHUNKS - 1; n >= 0; n--) begin
			if (avail[n]) begin
				found       = 1'b1;
				found_chunk = CHUNK_W'(n);
			end
		end
	end

	assign open_cnt = open_q;

endmodule

`default_nettype wire

@@ rtl/bitmap_block_allocator_core.sv @@
// bitmap_block_allocator_core: top level, request sequencer and result register
// depends on bba_pkg, bba_if, bba_ram and bba_summary
//
// Fixed-size block allocator, first fit over chunks of 32 blocks.
// Channels: req (sink) takes a request of command, block_index, clear_block;
// rsp (source) gives granted_index, byte_offset, clear_needed, status; cfg
// (sink) writes block_bytes and is always ready. Every request gives one
// result.
// An allocate that finds a chunk with room, and every in-range free, passes
// from acceptance to a valid result through S_FIND (search with bitmap read),
// S_MOD (bitmap modify and write-back) and S_OUT (result register). Opening a
// new chunk, pool full and a bad free skip the read and S_MOD. One request is
// in flight at a time: a new request is accepted only in S_IDLE, after the
// last has left S_OUT, as the bitmap memory has a single read-modify-write.
// Reset clears the open-chunk count and full flags; the bitmap memory needs
// no clearing pass, as a chunk's entry is written when it is opened.
// A stalled receiver holds the result register; a new request is still
// accepted and runs until its own result waits for the register to drain.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_block_allocator_core import bba_pkg::*; #(
	parameter int unsigned CHUNKS = CHUNKS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	bba_cfg_if.sink  cfg,
	bba_req_if.sink  req,
	bba_rsp_if.source rsp
);

	localparam int unsigned CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int unsigned OPEN_W  = $clog2(CHUNKS + 1);
	localparam int unsigned CMP_W   = (OPEN_W > FREE_CHUNK_W) ? OPEN_W : FREE_CHUNK_W;

	// sequencer state
	state_t state_q, state_nxt;

	// block size register
	logic [BYTES_W-1:0] block_bytes_q;

	// request captured at acceptance
	cmd_t               cmd_s1;
	logic [INDEX_W-1:0] idx_s1;
	logic               clr_s1;
	logic [CHUNK_W-1:0] chunk_s1;
	logic [CHUNK_W-1:0] chunk_nxt;
	logic               chunk_load;

	// pending result
	logic [INDEX_W-1:0] gidx_s2, gidx_nxt;
	logic               clr_s2, clr_nxt;
	status_t            st_s2, st_nxt;
	logic               res_load;

	// result register
	logic                out_valid_q;
	logic [INDEX_W-1:0]  out_gidx_q;
	logic [OFFSET_W-1:0] out_offset_q;
	logic                out_clr_q;
	status_t             out_st_q;
	logic                out_load;
	logic [PROD_W-1:0]   prod;

	// bitmap memory
	logic                        ram_we, ram_re;
	logic [CHUNK_W-1:0]          ram_waddr, ram_raddr;
	logic [BLOCKS_PER_CHUNK-1:0] ram_wdata, ram_rdata;

	// chunk summary
	sum_upd_t           upd;
	logic [OPEN_W-1:0]  open_cnt;
	logic               found;
	logic [CHUNK_W-1:0] found_chunk;

	// free target and bitmap edit
	logic [FREE_CHUNK_W-1:0]     free_chunk;
	logic [BIT_W-1:0]            free_bit;
	logic [BIT_W-1:0]            zero_bit;
	logic [BLOCKS_PER_CHUNK-1:0] bit_sel;

	logic req_fire;

	assign req_fire   = req.valid && req.ready;
	assign req.ready  = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;
	assign free_chunk = idx_s1[INDEX_W-1:BIT_W];
	assign free_bit   = idx_s1[BIT_W-1:0];

	bba_ram #(
		.WIDTH  (BLOCKS_PER_CHUNK),
		.DEPTH  (CHUNKS),
		.ADDR_W (CHUNK_W)
	) u_bitmap_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bba_summary #(
		.CHUNKS  (CHUNKS),
		.CHUNK_W (CHUNK_W),
		.OPEN_W  (OPEN_W)
	) u_summary (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (upd),
		.open_cnt    (open_cnt),
		.found       (found),
		.found_chunk (found_chunk)
	);

	// lowest free bit of the bitmap just read
	always_comb begin
		zero_bit = '0;
		for (int b = BLOCKS_PER_CHUNK - 1; b >= 0; b--) begin
			if (!ram_rdata[b]) begin
				zero_bit = BIT_W'(b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt  = state_q;
		ram_we     = 1'b0;
		ram_waddr  = '0;
		ram_wdata  = '0;
		ram_re     = 1'b0;
		ram_raddr  = '0;
		upd        = '0;
		chunk_load = 1'b0;
		chunk_nxt  = '0;
		res_load   = 1'b0;
		gidx_nxt   = '0;
		clr_nxt    = 1'b0;
		st_nxt     = ST_OK;
		out_load   = 1'b0;
		bit_sel    = '0;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					state_nxt = S_FIND;
				end
			end
			S_FIND: begin
				if (cmd_s1 == CMD_ALLOC) begin
					if (found) begin
						// chunk with room: fetch its bitmap
						ram_re     = 1'b1;
						ram_raddr  = found_chunk;
						chunk_load = 1'b1;
						chunk_nxt  = found_chunk;
						state_nxt  = S_MOD;
					end else if (open_cnt < OPEN_W'(CHUNKS)) begin
						// open the next chunk and grant its block 0
						ram_we     = 1'b1;
						ram_waddr  = CHUNK_W'(open_cnt);
						ram_wdata  = BLOCKS_PER_CHUNK'(1);
						upd.wr     = 1'b1;
						upd.open   = 1'b1;
						upd.full   = 1'b0;
						upd.chunk  = CHUNK_IDX_W_MAX'(open_cnt);
						res_load   = 1'b1;
						gidx_nxt   = INDEX_W'({CHUNK_W'(open_cnt), BIT_W'(0)});
						clr_nxt    = clr_s1;
						st_nxt     = ST_OK;
						state_nxt  = S_OUT;
					end else begin
						res_load  = 1'b1;
						st_nxt    = ST_POOL_FULL;
						state_nxt = S_OUT;
					end
				end else begin
					if (CMP_W'(free_chunk) < CMP_W'(open_cnt)) begin
						ram_re     = 1'b1;
						ram_raddr  = CHUNK_W'(free_chunk);
						chunk_load = 1'b1;
						chunk_nxt  = CHUNK_W'(free_chunk);
						state_nxt  = S_MOD;
					end else begin
						res_load  = 1'b1;
						st_nxt    = ST_BAD_FREE;
						state_nxt = S_OUT;
					end
				end
			end
			S_MOD: begin
				ram_we    = 1'b1;
				ram_waddr = chunk_s1;
				upd.wr    = 1'b1;
				upd.chunk = CHUNK_IDX_W_MAX'(chunk_s1);
				res_load  = 1'b1;
				st_nxt    = ST_OK;
				if (cmd_s1 == CMD_ALLOC) begin
					bit_sel[zero_bit] = 1'b1;
					ram_wdata = ram_rdata | bit_sel;
					upd.full  = (ram_wdata == '1);
					gidx_nxt  = INDEX_W'({chunk_s1, zero_bit});
					clr_nxt   = clr_s1;
				end else begin
					bit_sel[free_bit] = 1'b1;
					ram_wdata = ram_rdata & ~bit_sel;
					upd.full  = 1'b0;
				end
				state_nxt = S_OUT;
			end
			S_OUT: begin
				// wait for the result register to drain
				if (!out_valid_q || rsp.ready) begin
					out_load  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= BYTES_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			block_bytes_q <= cfg.block_bytes;
		end
	end

	// request and intermediate payload, no reset
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_s1 <= cmd_t'(req.command);
			idx_s1 <= req.block_index;
			clr_s1 <= req.clear_block;
		end
		if (chunk_load) begin
			chunk_s1 <= chunk_nxt;
		end
		if (res_load) begin
			gidx_s2 <= gidx_nxt;
			clr_s2  <= clr_nxt;
			st_s2   <= st_nxt;
		end
	end

	// byte offset wraps to its low bits
	assign prod = PROD_W'(gidx_s2) * PROD_W'(block_bytes_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_gidx_q   <= gidx_s2;
			out_offset_q <= prod[OFFSET_W-1:0];
			out_clr_q    <= clr_s2;
			out_st_q     <= st_s2;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.granted_index = out_gidx_q;
	assign rsp.byte_offset   = out_offset_q;
	assign rsp.clear_needed  = out_clr_q;
	assign rsp.status        = out_st_q;

	// open count stays within the pool
	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_cnt <= OPEN_W'(CHUNKS))
		else $error("open chunk count beyond pool size");

	// the summary only sends allocations to chunks that have room
	a_alloc_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD && cmd_s1 == CMD_ALLOC) |-> (ram_rdata != '1))
		else $error("allocation targeted a full chunk");

	// pool full is reported only with every chunk open
	a_full_all_open: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && st_s2 == ST_POOL_FULL) |-> (open_cnt == OPEN_W'(CHUNKS)))
		else $error("pool full reported with chunks left to open");

	// a result is loaded only after a request has gone through the search
	a_load_after_find: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> ($past(state_q) == S_FIND || $past(state_q) == S_MOD
			|| $past(state_q) == S_OUT))
		else $error("result loaded without a request in flight");

endmodule

`default_nettype wire
